@@ sv/lru_key_cache_defines.svh @@
// Assertion macros for the checker file of the LRU key cache.
// Depends on nothing; every macro expands to one labelled concurrent assertion.
`ifndef LRU_KEY_CACHE_DEFINES_SVH
`define LRU_KEY_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_key_cache: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_key_cache: next-cycle check failed");

`endif

@@ sv/lkc_pkg.sv @@
// Package for the LRU key cache: sizes, command codes and shared types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package lkc_pkg;

   // Number of slots and stored key width.
   localparam int CAPACITY = 5;
   localparam int KEY_BITS = 17;

   // Derived widths: slot index, recency rank and fill count.
   localparam int INDEX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_W  = INDEX_W;
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // Command codes.
   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_PROBE  = 1'b1;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [RANK_W-1:0]   rank_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [INDEX_W-1:0]  index_type;

   // One result transaction.
   typedef struct packed {
      logic      hit;
      logic      evicted;
      key_type   evicted_key;
      count_type entries_used;
   } result_type;

endpackage

@@ sv/lkc_update.sv @@
// Combinational lookup and replacement step of the LRU key cache.
// Depends on lkc_pkg; instantiated by lru_key_cache.
`timescale 1ns / 1ps

module lkc_update (
   input  logic                                       cmd,
   input  lkc_pkg::key_type                           key,
   input  lkc_pkg::key_type  [lkc_pkg::CAPACITY-1:0]  slot_keys_ff,
   input  logic              [lkc_pkg::CAPACITY-1:0]  slot_valid_ff,
   input  lkc_pkg::rank_type [lkc_pkg::CAPACITY-1:0]  slot_rank_ff,
   input  lkc_pkg::count_type                         fill_level_ff,
   output lkc_pkg::key_type  [lkc_pkg::CAPACITY-1:0]  slot_keys_in,
   output logic              [lkc_pkg::CAPACITY-1:0]  slot_valid_in,
   output lkc_pkg::rank_type [lkc_pkg::CAPACITY-1:0]  slot_rank_in,
   output lkc_pkg::count_type                         fill_level_in,
   output lkc_pkg::result_type                        result
);
   import lkc_pkg::*;

   logic [CAPACITY-1:0] match_vec;
   logic                hit;
   logic                full;
   index_type           match_idx;
   index_type           free_idx;
   index_type           victim_idx;
   index_type           ins_idx;
   rank_type            match_rank;

   // Key comparators, one per slot.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_vec[i] = slot_valid_ff[i] && (slot_keys_ff[i] == key);
      end
   end

   assign hit  = |match_vec;
   assign full = (fill_level_ff >= COUNT_W'(CAPACITY));

   // Lowest-numbered matching slot, free slot and least recent slot.
   always_comb begin
      match_idx  = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_idx = INDEX_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_idx = INDEX_W'(i);
         end
         if (slot_valid_ff[i] && (slot_rank_ff[i] == RANK_W'(CAPACITY - 1))) begin
            victim_idx = INDEX_W'(i);
         end
      end
   end

   assign match_rank = slot_rank_ff[match_idx];
   assign ins_idx    = full ? victim_idx : free_idx;

   // Next slot contents and recency ranks.
   always_comb begin
      slot_keys_in  = slot_keys_ff;
      slot_valid_in = slot_valid_ff;
      slot_rank_in  = slot_rank_ff;
      fill_level_in = fill_level_ff;
      if (hit) begin
         if (cmd == CMD_ACCESS) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (INDEX_W'(i) == match_idx) begin
                  slot_rank_in[i] = '0;
               end else if (slot_valid_ff[i] && (slot_rank_ff[i] < match_rank)) begin
                  slot_rank_in[i] = slot_rank_ff[i] + RANK_W'(1);
               end
            end
         end
      end else begin
         // Insertion: every other valid slot ages by one step.
         for (int i = 0; i < CAPACITY; i++) begin
            if (INDEX_W'(i) == ins_idx) begin
               slot_keys_in[i]  = key;
               slot_valid_in[i] = 1'b1;
               slot_rank_in[i]  = '0;
            end else if (slot_valid_ff[i]
                         && (COUNT_W'(slot_rank_ff[i]) < COUNT_W'(CAPACITY))) begin
               slot_rank_in[i] = slot_rank_ff[i] + RANK_W'(1);
            end
         end
         if (!full) begin
            fill_level_in = fill_level_ff + COUNT_W'(1);
         end
      end
   end

   // Result of this transaction.
   always_comb begin
      result.hit          = hit;
      result.evicted      = !hit && full;
      result.evicted_key  = (!hit && full) ? slot_keys_ff[victim_idx] : '0;
      result.entries_used = fill_level_in;
   end

endmodule

@@ sv/lru_key_cache.sv @@
// Top level of the LRU key cache: input register, slot state and result register.
// Depends on lkc_pkg and lkc_update.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_cmd, req_key
//   rsp       out        rsp_valid/rsp_stall  rsp_hit, rsp_evicted, rsp_evicted_key,
//                                             rsp_entries_used
//
// One transaction per cycle is taken and answered while rsp is not stalled; a
// request accepted into the input register is offered as a result once it
// advances into the result register.
// The lookup, victim choice and rank update for an item are combinational between
// those registers and commit when it advances, so the next item sees updated slots.
// Reset is synchronous and clears valid bits, ranks and fill count at once;
// slot keys are not cleared and no clearing pass is needed.
// A stall on rsp holds the result and, once the input register is occupied,
// raises req_stall in the same cycle.
`timescale 1ns / 1ps

module lru_key_cache (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  lkc_pkg::key_type     req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic                 rsp_evicted,
   output lkc_pkg::key_type     rsp_evicted_key,
   output lkc_pkg::count_type   rsp_entries_used
);
   import lkc_pkg::*;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic                        in_cmd_ff;
   key_type                     in_key_ff;
   logic                        advance;

   key_type  [CAPACITY-1:0]     slot_keys_ff;
   key_type  [CAPACITY-1:0]     slot_keys_in;
   logic     [CAPACITY-1:0]     slot_valid_ff;
   logic     [CAPACITY-1:0]     slot_valid_in;
   rank_type [CAPACITY-1:0]     slot_rank_ff;
   rank_type [CAPACITY-1:0]     slot_rank_in;
   count_type                   fill_level_ff;
   count_type                   fill_level_in;

   result_type                  result;
   result_type                  rsp_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;

   // The held transaction moves on when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_cmd_ff <= req_cmd;
         in_key_ff <= req_key;
      end
   end

   // Lookup and replacement for the held transaction.
   lkc_update u_update (
      .cmd           (in_cmd_ff),
      .key           (in_key_ff),
      .slot_keys_ff  (slot_keys_ff),
      .slot_valid_ff (slot_valid_ff),
      .slot_rank_ff  (slot_rank_ff),
      .fill_level_ff (fill_level_ff),
      .slot_keys_in  (slot_keys_in),
      .slot_valid_in (slot_valid_in),
      .slot_rank_in  (slot_rank_in),
      .fill_level_in (fill_level_in),
      .result        (result)
   );

   // Slot state, committed when the transaction advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         slot_rank_ff  <= '0;
         fill_level_ff <= '0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
         slot_rank_ff  <= slot_rank_in;
         fill_level_ff <= fill_level_in;
      end
      if (advance) begin
         slot_keys_ff <= slot_keys_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_evicted      = rsp_ff.evicted;
   assign rsp_evicted_key  = rsp_ff.evicted_key;
   assign rsp_entries_used = rsp_ff.entries_used;

endmodule

@@ sv/lkc_checker.sv @@
// Port-level checks for the LRU key cache, bound to the top level.
// Depends on lkc_pkg and lru_key_cache_defines.svh.
`timescale 1ns / 1ps
`include "lru_key_cache_defines.svh"

module lkc_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_hit,
   input  logic                 rsp_evicted,
   input  lkc_pkg::key_type     rsp_evicted_key,
   input  lkc_pkg::count_type   rsp_entries_used
);
   import lkc_pkg::*;

   // The fill count never passes the number of slots.
   `LKC_ASSERT_SAME(a_fill_bound, clock, reset, rsp_valid, rsp_entries_used <= COUNT_W'(CAPACITY))

   // Replacement happens only on a miss with every slot in use.
   `LKC_ASSERT_SAME(a_evict_full, clock, reset, rsp_valid && rsp_evicted, !rsp_hit && (rsp_entries_used == COUNT_W'(CAPACITY)))

   // Without replacement the reported key is zero.
   `LKC_ASSERT_SAME(a_evict_key_zero, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_key == '0)

   // A stalled result transaction stays offered unchanged.
   `LKC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted) && $stable(rsp_evicted_key) && $stable(rsp_entries_used))

endmodule

bind lru_key_cache lkc_checker u_lkc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit          (rsp_hit),
   .rsp_evicted      (rsp_evicted),
   .rsp_evicted_key  (rsp_evicted_key),
   .rsp_entries_used (rsp_entries_used)
);

@@ tb/lru_key_cache_tb.sv @@
// Self-checking testbench for the LRU key cache: directed table, then random traffic.
// Depends on lkc_pkg and lru_key_cache; own recency model predicts untyped results.
`timescale 1ns / 1ps

module lru_key_cache_tb;
   import lkc_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;
   localparam int POOL_SIZE    = 7;

   typedef struct packed {
      logic       cmd;
      key_type    key;
      logic       typed;
      result_type want;
   } stim_row_type;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_cmd   = CMD_ACCESS;
   key_type   req_key   = '0;
   logic      rsp_stall = 1'b0;
   logic      req_stall;
   logic      rsp_valid;
   logic      rsp_hit;
   logic      rsp_evicted;
   key_type   rsp_evicted_key;
   count_type rsp_entries_used;

   // Own copy of the slot state, used only for prediction.
   key_type     slot_key  [CAPACITY];
   bit          slot_live [CAPACITY];
   int unsigned slot_age  [CAPACITY];
   int unsigned occupancy = 0;

   result_type   pending_results [$];
   stim_row_type directed_rows [$];
   key_type      key_pool [POOL_SIZE];
   int           mismatches   = 0;
   int           cycle_count  = 0;
   int           hold_left    = 0;
   bit           hold_request = 1'b0;
   bit           steady       = 1'b0;

   lru_key_cache dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_key  (rsp_evicted_key),
      .rsp_entries_used (rsp_entries_used)
   );

   // Free-running clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Every live slot younger than the given rank becomes one step older.
   function automatic void make_older(input int unsigned limit);
      for (int i = 0; i < CAPACITY; i++) begin
         if (slot_live[i] && slot_age[i] < limit)
            slot_age[i]++;
      end
   endfunction

   // Looks the key up, updates recency and returns the result the cache should give.
   function automatic result_type cache_lookup(input logic cmd, input key_type key);
      result_type  res;
      int          match;
      int          slot;
      res   = '0;
      match = -1;
      slot  = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match < 0 && slot_live[i] && slot_key[i] == key)
            match = i;
      end
      if (match >= 0) begin
         res.hit = 1'b1;
         if (cmd == CMD_ACCESS) begin
            make_older(slot_age[match]);
            slot_age[match] = 0;
         end
      end else if (occupancy < CAPACITY) begin
         // Still filling: take the lowest free slot.
         for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!slot_live[i])
               slot = i;
         end
         make_older(CAPACITY);
         slot_key[slot]  = key;
         slot_live[slot] = 1'b1;
         slot_age[slot]  = 0;
         occupancy++;
      end else begin
         // Full: replace the oldest entry and report its key.
         for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (slot_live[i] && slot_age[i] == CAPACITY - 1)
               slot = i;
         end
         res.evicted     = 1'b1;
         res.evicted_key = slot_key[slot];
         slot_live[slot] = 1'b0;
         make_older(CAPACITY);
         slot_key[slot]  = key;
         slot_live[slot] = 1'b1;
         slot_age[slot]  = 0;
      end
      res.entries_used = count_type'(occupancy);
      return res;
   endfunction

   // Adds one row to the directed table; the typed result is used only when typed is set.
   function automatic void add_row(input logic cmd, input key_type key, input logic typed,
                                   input logic hit, input logic evicted,
                                   input key_type evicted_key, input count_type used);
      stim_row_type row;
      row.cmd                = cmd;
      row.key                = key;
      row.typed              = typed;
      row.want.hit           = hit;
      row.want.evicted       = evicted;
      row.want.evicted_key   = evicted_key;
      row.want.entries_used  = used;
      directed_rows.push_back(row);
   endfunction

   // Offers one transaction, waits for it to be taken and records its expected result.
   task automatic offer_item(input logic cmd, input key_type key, input logic typed,
                             input result_type want);
      result_type predicted;
      while (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      do
         @(posedge clock);
      while (req_stall);
      predicted = cache_lookup(cmd, key);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Holds the sender back until every outstanding result has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Result side: check each accepted transaction, then choose the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result transaction arrived with nothing expected");
               mismatches++;
            end else begin
               result_type exp_res;
               exp_res = pending_results.pop_front();
               if (rsp_hit !== exp_res.hit) begin
                  $error("hit: expected %0d, got %0d", exp_res.hit, rsp_hit);
                  mismatches++;
               end
               if (rsp_evicted !== exp_res.evicted) begin
                  $error("evicted: expected %0d, got %0d", exp_res.evicted, rsp_evicted);
                  mismatches++;
               end
               if (rsp_evicted_key !== exp_res.evicted_key) begin
                  $error("evicted_key: expected %0h, got %0h",
                         exp_res.evicted_key, rsp_evicted_key);
                  mismatches++;
               end
               if (rsp_entries_used !== exp_res.entries_used) begin
                  $error("entries_used: expected %0d, got %0d",
                         exp_res.entries_used, rsp_entries_used);
                  mismatches++;
               end
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 14);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lru_key_cache_tb: FAIL");
         $finish;
      end
   end

   initial begin
      result_type blank;
      key_type    key;
      logic       cmd;
      blank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         slot_key[i]  = '0;
         slot_live[i] = 1'b0;
         slot_age[i]  = 0;
      end

      // Fill from empty with the key extremes, then hits, probes and evictions.
      add_row(CMD_ACCESS, 17'h00000, 1'b1, 1'b0, 1'b0, 17'h00000, 3'd1);
      add_row(CMD_ACCESS, 17'h1FFFF, 1'b1, 1'b0, 1'b0, 17'h00000, 3'd2);
      add_row(CMD_PROBE,  17'h1FFFF, 1'b1, 1'b1, 1'b0, 17'h00000, 3'd2);
      add_row(CMD_ACCESS, 17'h1FFFF, 1'b1, 1'b1, 1'b0, 17'h00000, 3'd2);
      add_row(CMD_ACCESS, 17'h0AAAA, 1'b1, 1'b0, 1'b0, 17'h00000, 3'd3);
      add_row(CMD_ACCESS, 17'h15555, 1'b1, 1'b0, 1'b0, 17'h00000, 3'd4);
      add_row(CMD_PROBE,  17'h00001, 1'b1, 1'b0, 1'b0, 17'h00000, 3'd5);
      add_row(CMD_PROBE,  17'h00000, 1'b1, 1'b1, 1'b0, 17'h00000, 3'd5);
      add_row(CMD_ACCESS, 17'h10000, 1'b1, 1'b0, 1'b1, 17'h00000, 3'd5);
      add_row(CMD_ACCESS, 17'h1FFFF, 1'b1, 1'b1, 1'b0, 17'h00000, 3'd5);
      add_row(CMD_ACCESS, 17'h00002, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_PROBE,  17'h15555, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_PROBE,  17'h00003, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_ACCESS, 17'h00001, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_ACCESS, 17'h00001, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_ACCESS, 17'h00000, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_PROBE,  17'h1FFFF, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_ACCESS, 17'h1FFFE, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_PROBE,  17'h10000, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);
      add_row(CMD_ACCESS, 17'h0FFFF, 1'b0, 1'b0, 1'b0, 17'h00000, 3'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_item(directed_rows[i].cmd, directed_rows[i].key,
                    directed_rows[i].typed, directed_rows[i].want);

      // Random traffic drawn mostly from a small pool of keys so that hits and
      // evictions both stay frequent; the rest spans the full key range.
      foreach (key_pool[i])
         key_pool[i] = key_type'($urandom());
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            hold_request = 1'b1;
         if (n == 600 || n == 1500)
            drain_results();
         steady = (n >= 900 && n < 1200);
         if ($urandom_range(49) == 0)
            key_pool[$urandom_range(POOL_SIZE - 1)] = key_type'($urandom());
         if ($urandom_range(99) < 70)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else
            key = key_type'($urandom());
         cmd = ($urandom_range(99) < 55) ? CMD_ACCESS : CMD_PROBE;
         offer_item(cmd, key, 1'b0, blank);
      end
      steady = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("lru_key_cache_tb: PASS");
      else
         $display("lru_key_cache_tb: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/lkc_pkg.sv
sv/lkc_update.sv
sv/lru_key_cache.sv
sv/lkc_checker.sv
tb/lru_key_cache_tb.sv
